// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the word table RTL. The checks compile away
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checks that a property holds at every clock edge out of reset.
`define WTD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("word table assertion failed");
// Checks that a condition never holds at a clock edge out of reset.
`define WTD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("word table forbidden condition seen");
`else
`define WTD_ASSERT(lbl, prop)
`define WTD_NEVER(lbl, cond)
`endif

`endif

// ===== sv/wtd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtd_pkg
// Types and constants shared by the sorted word frequency table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtd_pkg;

    localparam int WORD_W  = 56;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One input request.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_final;
    } in_req_t;

    // One emitted table entry.
    typedef struct packed {
        logic [WORD_W-1:0]  entry_word;
        logic [COUNT_W-1:0] occurrences;
        logic               table_overflow;
        logic               end_of_run;
    } result_t;

    // Contents of one table cell.
    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              upd;     // count or insert the broadcast word
        logic              shift;   // emit: every cell takes its right neighbor
        logic              hit;     // some cell already holds the word
        logic              do_ins;  // word is new and the table has room
        logic [WORD_W-1:0] word;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/word_table_dedup_count_sort.sv =====
// A non-final request updates the cell registers directly; start may be high every cycle while busy is low.
// A final request is counted like any other, then one entry is emitted per cycle, and busy
// holds until every distinct word (1 to MAX_ENTRIES) is out; each result follows in the cycle
// after its entry leaves the head, from the output register fed by the head cell of the chain.
// The receiver cannot stall: each result is shown for exactly one cycle on result_valid.
// Reset clears all cell occupancy bits and the overflow flag in one step; no sweep is needed.
// ----------------------------------------------------------------------------
// word_table_dedup_count_sort
// Sorted table of distinct words with saturating counts, built as a chain of
// compare cells. On the final request the chain shifts out in ascending order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module word_table_dedup_count_sort #(
    parameter int MAX_ENTRIES = 64,
    parameter int WORD_BYTES  = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire wtd_pkg::in_req_t item,
    output wtd_pkg::result_t      result,
    output logic                  result_valid
);

    localparam logic [wtd_pkg::WORD_W-1:0] WORD_MASK =
        {wtd_pkg::WORD_W{1'b1}} >> (wtd_pkg::WORD_W - WORD_BYTES * 8);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic               overflow_reg;
    wtd_pkg::result_t   result_reg;
    logic               result_valid_reg;

    wtd_pkg::cell_ctl_t ctl;
    wtd_pkg::entry_t    entries   [MAX_ENTRIES];
    wtd_pkg::entry_t    left_in   [MAX_ENTRIES];
    wtd_pkg::entry_t    right_in  [MAX_ENTRIES];
    logic               left_aft  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] after_vec;
    logic [MAX_ENTRIES-1:0] hit_vec;

    logic accept;
    logic match_any;
    logic table_full;
    logic last_out;

    assign accept     = start && (state_reg == ST_IDLE);
    assign match_any  = |hit_vec;
    assign table_full = entries[MAX_ENTRIES-1].valid;
    assign last_out   = !entries[1].valid;

    // Broadcast control to the chain.
    always_comb
    begin
        ctl.upd    = accept;
        ctl.shift  = (state_reg == ST_EMIT);
        ctl.hit    = match_any;
        ctl.do_ins = !match_any && !table_full;
        ctl.word   = item.word & WORD_MASK;
    end

    // Cell chain with neighbor links; the ends see an empty entry.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_in[i]  = '0;
            assign left_aft[i] = 1'b0;
        end
        else
        begin : g_body
            assign left_in[i]  = entries[i-1];
            assign left_aft[i] = after_vec[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign right_in[i] = '0;
        end
        else
        begin : g_link
            assign right_in[i] = entries[i+1];
        end

        wtd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .left       (left_in[i]),
            .left_after (left_aft[i]),
            .right      (right_in[i]),
            .entry      (entries[i]),
            .after      (after_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    // Sequencer, overflow flag and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            overflow_reg     <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!match_any && table_full)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (item.is_final)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    result_valid_reg          <= 1'b1;
                    result_reg.entry_word     <= entries[0].word;
                    result_reg.occurrences    <= entries[0].count;
                    result_reg.table_overflow <= overflow_reg;
                    result_reg.end_of_run     <= last_out;
                    if (last_out)
                    begin
                        overflow_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg == ST_EMIT);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // The chain stays packed toward the head and strictly ascending.
    for (genvar j = 1; j < MAX_ENTRIES; j++)
    begin : g_chk
        `WTD_ASSERT(a_sorted, entries[j].valid |-> (entries[j-1].valid && (entries[j-1].word < entries[j].word)))
    end

    // The table is never empty while it is being emitted.
    `WTD_ASSERT(a_emit_nonempty, busy |-> entries[0].valid)

    // An emitted entry always carries a nonzero count.
    `WTD_NEVER(a_zero_count, result_valid && (result.occurrences == '0))

    // By the time the last entry is shown the block takes requests again.
    `WTD_ASSERT(a_end_idle, (result_valid && result.end_of_run) |-> !busy)

endmodule

`default_nettype wire

// ===== sv/wtd_cell.sv =====
// ----------------------------------------------------------------------------
// wtd_cell
// One table cell: holds a word and its count, compares against the
// broadcast word, and moves entries to or from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtd_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wtd_pkg::cell_ctl_t ctl,
    input  wire wtd_pkg::entry_t   left,
    input  wire logic              left_after,
    input  wire wtd_pkg::entry_t   right,
    output wtd_pkg::entry_t        entry,
    output logic                   after,
    output logic                   hit
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [wtd_pkg::WORD_W-1:0]  word_reg;
    logic [wtd_pkg::WORD_W-1:0]  word_next;
    logic [wtd_pkg::COUNT_W-1:0] count_reg;
    logic [wtd_pkg::COUNT_W-1:0] count_next;

    // This cell sits at or past the sorted insert point of the word.
    assign after = !valid_reg || (word_reg > ctl.word);
    assign hit   = valid_reg && (word_reg == ctl.word);

    assign entry = '{valid: valid_reg, word: word_reg, count: count_reg};

    // Next contents: shift out, count a match, or make room for an insert.
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        count_next = count_reg;
        if (ctl.shift)
        begin
            valid_next = right.valid;
            word_next  = right.word;
            count_next = right.count;
        end
        else if (ctl.upd)
        begin
            if (ctl.hit)
            begin
                if (hit && (count_reg != wtd_pkg::COUNT_MAX))
                begin
                    count_next = count_reg + wtd_pkg::COUNT_W'(1);
                end
            end
            else if (ctl.do_ins)
            begin
                if (left_after)
                begin
                    valid_next = left.valid;
                    word_next  = left.word;
                    count_next = left.count;
                end
                else if (after)
                begin
                    valid_next = 1'b1;
                    word_next  = ctl.word;
                    count_next = wtd_pkg::COUNT_W'(1);
                end
            end
        end
    end

    // Occupancy is control state and clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Word and count are only meaningful while the cell is occupied.
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
    end

endmodule

`default_nettype wire
